/* design/moesi_pkg.sv */
// ----------------------------------------------------------------------------
// moesi_pkg
// Shared types and constants for the MOESI snooping coherence controller.
// ----------------------------------------------------------------------------
package moesi_pkg;

   // Number of tracked lines; must be a power of two (index is taken modulo).
   localparam int NUM_LINES  = 256;
   localparam int IDX_W      = $clog2(NUM_LINES);
   localparam int LINE_IDX_W = 8;
   localparam int ADDR_W     = 32;
   localparam int NODE_W     = 4;

   typedef enum logic [3:0] {
      ST_I  = 4'd0,
      ST_S  = 4'd1,
      ST_E  = 4'd2,
      ST_O  = 4'd3,
      ST_M  = 4'd4,
      ST_IM = 4'd5,
      ST_IS = 4'd6,
      ST_SM = 4'd7,
      ST_OM = 4'd8
   } line_state_type;

   typedef enum logic [2:0] {
      CMD_LOAD  = 3'd0,
      CMD_STORE = 3'd1,
      CMD_GETS  = 3'd2,
      CMD_GETM  = 3'd3,
      CMD_DATA  = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      BUS_NONE = 2'd0,
      BUS_GETS = 2'd1,
      BUS_GETM = 2'd2
   } bus_req_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_UNEXPECTED = 2'd1,
      ERR_TRANSIENT = 2'd2
   } err_type;

   // One input item as held while its line state is looked up.
   typedef struct packed {
      cmd_type           cmd;
      logic [IDX_W-1:0]  idx;
      logic [ADDR_W-1:0] block_addr;
      logic [NODE_W-1:0] requester_id;
      logic              shared_seen;
   } req_type;

   // One result item.
   typedef struct packed {
      bus_req_type       bus_request;
      logic              data_on_bus;
      logic [NODE_W-1:0] data_dest;
      logic [ADDR_W-1:0] out_addr;
      logic              data_to_proc;
      logic              assert_shared;
      logic              miss;
      logic              silent_upgrade;
      err_type           error_code;
      line_state_type    new_state;
   } rsp_type;

endpackage

/* design/moesi_coherence_controller_top.sv */
// ----------------------------------------------------------------------------
// moesi_coherence_controller_top
// The item and its line state read are registered at accept, and the result
// is loaded into the output register once that register is free. No new item
// is taken until then, set by the read-modify-write of the line state memory
// (read issued at accept, write back when the result loads).
// Reset: all lines read as Invalid at once via per-line valid flags; there is
// no clearing pass, and items are taken from the first cycle after reset.
// ----------------------------------------------------------------------------
module moesi_coherence_controller_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // line_index[7:0], block_addr[39:8], requester_id[43:40], shared_seen[44], zero pad
   input  logic [47:0] req_tdata,
   // cmd[2:0]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // bus_request[1:0], data_on_bus[2], data_dest[6:3], out_addr[38:7],
   // data_to_proc[39], assert_shared[40], miss[41], silent_upgrade[42],
   // error_code[44:43], new_state[48:45], zero pad
   output logic [55:0] rsp_tdata
);

   logic                      accept;
   logic                      out_free;
   logic                      done;
   logic                      busy_ff;
   logic                      busy_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   moesi_pkg::req_type        req_ff;
   moesi_pkg::req_type        req_in;
   moesi_pkg::rsp_type        rsp_ff;
   moesi_pkg::rsp_type        rsp_calc;
   moesi_pkg::line_state_type cur_state;

   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign done       = busy_ff && out_free;

   // The line index is reduced modulo the store depth by its low bits.
   always_comb begin
      req_in.cmd          = moesi_pkg::cmd_type'(req_tuser);
      req_in.idx          = req_tdata[moesi_pkg::IDX_W-1:0];
      req_in.block_addr   = req_tdata[39:8];
      req_in.requester_id = req_tdata[43:40];
      req_in.shared_seen  = req_tdata[44];
   end

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_in;
      end
      if (done) begin
         rsp_ff <= rsp_calc;
      end
   end

   // The next read starts only after this write has landed, so the same
   // line never needs forwarding.
   moesi_state_ram u_state_ram (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_idx   (req_in.idx),
      .wr_en    (done),
      .wr_idx   (req_ff.idx),
      .wr_state (rsp_calc.new_state),
      .rd_state (cur_state)
   );

   moesi_next_state u_next_state (
      .req (req_ff),
      .cur (cur_state),
      .rsp (rsp_calc)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff.new_state, rsp_ff.error_code, rsp_ff.silent_upgrade,
                        rsp_ff.miss, rsp_ff.assert_shared, rsp_ff.data_to_proc,
                        rsp_ff.out_addr, rsp_ff.data_dest, rsp_ff.data_on_bus,
                        rsp_ff.bus_request};

endmodule

/* design/moesi_state_ram.sv */
// ----------------------------------------------------------------------------
// moesi_state_ram
// Line state store: a one-read, one-write synchronous memory with per-line
// valid flags so that every line reads as Invalid right after reset.
// ----------------------------------------------------------------------------
module moesi_state_ram (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             rd_en,
   input  logic [moesi_pkg::IDX_W-1:0]      rd_idx,
   input  logic                             wr_en,
   input  logic [moesi_pkg::IDX_W-1:0]      wr_idx,
   input  moesi_pkg::line_state_type        wr_state,
   output moesi_pkg::line_state_type        rd_state
);

   moesi_pkg::line_state_type mem [moesi_pkg::NUM_LINES];
   logic [moesi_pkg::NUM_LINES-1:0] valid_ff;
   logic [moesi_pkg::NUM_LINES-1:0] valid_in;
   moesi_pkg::line_state_type       rd_data_ff;
   logic                            rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_state;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= mem[rd_idx];
         rd_valid_ff <= valid_ff[rd_idx];
      end
   end

   // A line never written since reset is Invalid.
   assign rd_state = rd_valid_ff ? rd_data_ff : moesi_pkg::ST_I;

endmodule

/* design/moesi_next_state.sv */
// ----------------------------------------------------------------------------
// moesi_next_state
// MOESI transition and action logic for one processor request or one
// snooped bus message against the current state of its line.
// ----------------------------------------------------------------------------
module moesi_next_state (
   input  moesi_pkg::req_type         req,
   input  moesi_pkg::line_state_type  cur,
   output moesi_pkg::rsp_type         rsp
);

   moesi_pkg::line_state_type nxt;
   moesi_pkg::bus_req_type    bus_req;
   moesi_pkg::err_type        err;
   logic                      bus;
   logic                      proc;
   logic                      ash;
   logic                      miss;
   logic                      silent;
   logic                      is_store;

   assign is_store = (req.cmd == moesi_pkg::CMD_STORE);

   always_comb begin
      nxt     = cur;
      bus_req = moesi_pkg::BUS_NONE;
      err     = moesi_pkg::ERR_NONE;
      bus     = 1'b0;
      proc    = 1'b0;
      ash     = 1'b0;
      miss    = 1'b0;
      silent  = 1'b0;
      unique case (req.cmd)
         moesi_pkg::CMD_LOAD, moesi_pkg::CMD_STORE: begin
            unique case (cur)
               moesi_pkg::ST_I: begin
                  bus_req = is_store ? moesi_pkg::BUS_GETM : moesi_pkg::BUS_GETS;
                  nxt     = is_store ? moesi_pkg::ST_IM : moesi_pkg::ST_IS;
                  miss    = 1'b1;
               end
               moesi_pkg::ST_S, moesi_pkg::ST_O: begin
                  if (is_store) begin
                     bus_req = moesi_pkg::BUS_GETM;
                     nxt     = (cur == moesi_pkg::ST_S) ? moesi_pkg::ST_SM
                                                        : moesi_pkg::ST_OM;
                     miss    = 1'b1;
                  end else begin
                     proc = 1'b1;
                  end
               end
               moesi_pkg::ST_E: begin
                  proc = 1'b1;
                  if (is_store) begin
                     nxt    = moesi_pkg::ST_M;
                     silent = 1'b1;
                  end
               end
               moesi_pkg::ST_M: begin
                  proc = 1'b1;
               end
               default: begin
                  err = moesi_pkg::ERR_TRANSIENT;
               end
            endcase
         end
         moesi_pkg::CMD_GETS, moesi_pkg::CMD_GETM, moesi_pkg::CMD_DATA: begin
            unique case (cur)
               moesi_pkg::ST_I: begin
               end
               moesi_pkg::ST_S: begin
                  if (req.cmd == moesi_pkg::CMD_DATA) begin
                     err = moesi_pkg::ERR_UNEXPECTED;
                  end else begin
                     ash = 1'b1;
                     if (req.cmd == moesi_pkg::CMD_GETM) begin
                        nxt = moesi_pkg::ST_I;
                     end
                  end
               end
               moesi_pkg::ST_E, moesi_pkg::ST_O, moesi_pkg::ST_M: begin
                  if (req.cmd == moesi_pkg::CMD_DATA) begin
                     err = moesi_pkg::ERR_UNEXPECTED;
                  end else begin
                     bus = 1'b1;
                     if (req.cmd == moesi_pkg::CMD_GETS) begin
                        ash = 1'b1;
                        // An owner keeps ownership; E drops to S, M to O.
                        if (cur == moesi_pkg::ST_E) begin
                           nxt = moesi_pkg::ST_S;
                        end else if (cur == moesi_pkg::ST_M) begin
                           nxt = moesi_pkg::ST_O;
                        end
                     end else begin
                        nxt = moesi_pkg::ST_I;
                     end
                  end
               end
               moesi_pkg::ST_IM: begin
                  if (req.cmd == moesi_pkg::CMD_DATA) begin
                     proc = 1'b1;
                     nxt  = moesi_pkg::ST_M;
                  end
               end
               moesi_pkg::ST_SM: begin
                  if (req.cmd == moesi_pkg::CMD_GETS) begin
                     ash = 1'b1;
                  end else if (req.cmd == moesi_pkg::CMD_DATA) begin
                     proc = 1'b1;
                     nxt  = moesi_pkg::ST_M;
                  end
               end
               moesi_pkg::ST_OM: begin
                  // Still the owner while the upgrade is pending.
                  if (req.cmd == moesi_pkg::CMD_GETS) begin
                     ash = 1'b1;
                     bus = 1'b1;
                  end else if (req.cmd == moesi_pkg::CMD_GETM) begin
                     bus = 1'b1;
                     nxt = moesi_pkg::ST_IM;
                  end else begin
                     proc = 1'b1;
                     nxt  = moesi_pkg::ST_M;
                  end
               end
               moesi_pkg::ST_IS: begin
                  if (req.cmd == moesi_pkg::CMD_DATA) begin
                     proc = 1'b1;
                     nxt  = req.shared_seen ? moesi_pkg::ST_S : moesi_pkg::ST_E;
                  end
               end
               default: begin
                  err = moesi_pkg::ERR_UNEXPECTED;
               end
            endcase
         end
         default: begin
            err = moesi_pkg::ERR_UNEXPECTED;
         end
      endcase
   end

   always_comb begin
      rsp.bus_request    = bus_req;
      rsp.data_on_bus    = bus;
      rsp.data_dest      = bus ? req.requester_id : '0;
      rsp.out_addr       = ((bus_req != moesi_pkg::BUS_NONE) || bus || proc)
                           ? req.block_addr : '0;
      rsp.data_to_proc   = proc;
      rsp.assert_shared  = ash;
      rsp.miss           = miss;
      rsp.silent_upgrade = silent;
      rsp.error_code     = err;
      rsp.new_state      = nxt;
   end

endmodule

/* sim/tb_moesi_coherence_controller_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_moesi_coherence_controller_top
// Drives processor requests and snooped bus messages into the MOESI
// controller. A short table walks every stable and transient state. Random
// traffic follows, mostly on sixteen lines, so that full coherence sequences
// form. Every result transfer is checked field by field against an in-bench
// model of the line states or a fixed result, in three phases of stalling.
// ----------------------------------------------------------------------------
module tb_moesi_coherence_controller_top;

   localparam int                 STALL_LIMIT = 2000;
   localparam int                 PHASE_ITEMS = 483;
   localparam logic [2:0]         CMD_RSVD_LO = 3'd5;
   localparam logic [2:0]         CMD_RSVD_HI = 3'd7;
   localparam moesi_pkg::rsp_type NO_FIXED    = '0;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [7:0]  line;
      logic [31:0] addr;
      logic [3:0]  rid;
      logic        shr;
   } coh_item_type;

   typedef struct {
      coh_item_type       item;
      bit                 typed;
      moesi_pkg::rsp_type want;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;

   moesi_pkg::line_state_type line_shadow [moesi_pkg::NUM_LINES];
   moesi_pkg::rsp_type        pending_rsp [$];
   dir_row_type               dir_tab [$];
   int                        mismatches;
   int                        snd_idle_pct;
   int                        rcv_idle_pct;
   int                        hold_left;
   int                        stall_cycles;

   moesi_coherence_controller_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Applies one item to the shadow line states and returns its result.
   function automatic moesi_pkg::rsp_type coherence_step(input coh_item_type it);
      int                        idx;
      moesi_pkg::line_state_type cur;
      moesi_pkg::line_state_type nxt;
      moesi_pkg::rsp_type        r;
      logic                      st;
      idx = int'(it.line) % moesi_pkg::NUM_LINES;
      cur = line_shadow[idx];
      nxt = cur;
      r = '0;
      st = (it.cmd == moesi_pkg::CMD_STORE);
      case (it.cmd)
         moesi_pkg::CMD_LOAD, moesi_pkg::CMD_STORE: begin
            case (cur)
               moesi_pkg::ST_I: begin
                  r.bus_request = st ? moesi_pkg::BUS_GETM : moesi_pkg::BUS_GETS;
                  nxt = st ? moesi_pkg::ST_IM : moesi_pkg::ST_IS;
                  r.miss = 1'b1;
               end
               moesi_pkg::ST_S, moesi_pkg::ST_O: begin
                  if (st) begin
                     r.bus_request = moesi_pkg::BUS_GETM;
                     nxt = (cur == moesi_pkg::ST_S) ? moesi_pkg::ST_SM : moesi_pkg::ST_OM;
                     r.miss = 1'b1;
                  end else begin
                     r.data_to_proc = 1'b1;
                  end
               end
               moesi_pkg::ST_E: begin
                  r.data_to_proc = 1'b1;
                  if (st) begin
                     nxt = moesi_pkg::ST_M;
                     r.silent_upgrade = 1'b1;
                  end
               end
               moesi_pkg::ST_M: r.data_to_proc = 1'b1;
               default: r.error_code = moesi_pkg::ERR_TRANSIENT;
            endcase
         end
         moesi_pkg::CMD_GETS, moesi_pkg::CMD_GETM, moesi_pkg::CMD_DATA: begin
            // A line that already holds the block never expects data.
            if (it.cmd == moesi_pkg::CMD_DATA &&
                (cur == moesi_pkg::ST_S || cur == moesi_pkg::ST_E ||
                 cur == moesi_pkg::ST_O || cur == moesi_pkg::ST_M)) begin
               r.error_code = moesi_pkg::ERR_UNEXPECTED;
            end else begin
               case (cur)
                  moesi_pkg::ST_S: begin
                     r.assert_shared = 1'b1;
                     if (it.cmd == moesi_pkg::CMD_GETM) nxt = moesi_pkg::ST_I;
                  end
                  moesi_pkg::ST_E: begin
                     r.data_on_bus = 1'b1;
                     if (it.cmd == moesi_pkg::CMD_GETS) begin
                        r.assert_shared = 1'b1;
                        nxt = moesi_pkg::ST_S;
                     end else begin
                        nxt = moesi_pkg::ST_I;
                     end
                  end
                  moesi_pkg::ST_O: begin
                     r.data_on_bus = 1'b1;
                     if (it.cmd == moesi_pkg::CMD_GETS) r.assert_shared = 1'b1;
                     else nxt = moesi_pkg::ST_I;
                  end
                  moesi_pkg::ST_M: begin
                     r.data_on_bus = 1'b1;
                     if (it.cmd == moesi_pkg::CMD_GETS) begin
                        r.assert_shared = 1'b1;
                        nxt = moesi_pkg::ST_O;
                     end else begin
                        nxt = moesi_pkg::ST_I;
                     end
                  end
                  moesi_pkg::ST_IM: begin
                     if (it.cmd == moesi_pkg::CMD_DATA) begin
                        r.data_to_proc = 1'b1;
                        nxt = moesi_pkg::ST_M;
                     end
                  end
                  moesi_pkg::ST_SM: begin
                     if (it.cmd == moesi_pkg::CMD_GETS) begin
                        r.assert_shared = 1'b1;
                     end else if (it.cmd == moesi_pkg::CMD_DATA) begin
                        r.data_to_proc = 1'b1;
                        nxt = moesi_pkg::ST_M;
                     end
                  end
                  moesi_pkg::ST_OM: begin
                     // The owner still supplies data while its upgrade is pending.
                     if (it.cmd == moesi_pkg::CMD_GETS) begin
                        r.assert_shared = 1'b1;
                        r.data_on_bus = 1'b1;
                     end else if (it.cmd == moesi_pkg::CMD_GETM) begin
                        r.data_on_bus = 1'b1;
                        nxt = moesi_pkg::ST_IM;
                     end else begin
                        r.data_to_proc = 1'b1;
                        nxt = moesi_pkg::ST_M;
                     end
                  end
                  moesi_pkg::ST_IS: begin
                     if (it.cmd == moesi_pkg::CMD_DATA) begin
                        r.data_to_proc = 1'b1;
                        nxt = it.shr ? moesi_pkg::ST_S : moesi_pkg::ST_E;
                     end
                  end
                  default: ;
               endcase
            end
         end
         default: r.error_code = moesi_pkg::ERR_UNEXPECTED;
      endcase
      r.data_dest = r.data_on_bus ? it.rid : 4'd0;
      if (r.bus_request != moesi_pkg::BUS_NONE || r.data_on_bus || r.data_to_proc)
         r.out_addr = it.addr;
      r.new_state = nxt;
      line_shadow[idx] = nxt;
      return r;
   endfunction

   function automatic moesi_pkg::rsp_type fixed_rsp(input moesi_pkg::bus_req_type req,
                                                    input logic [31:0] addr,
                                                    input logic miss,
                                                    input moesi_pkg::err_type err,
                                                    input moesi_pkg::line_state_type st);
      moesi_pkg::rsp_type r;
      r = '0;
      r.bus_request = req;
      r.out_addr = addr;
      r.miss = miss;
      r.error_code = err;
      r.new_state = st;
      return r;
   endfunction

   task automatic add_row(input logic [2:0] cmd, input logic [7:0] line,
                          input logic [31:0] addr, input logic [3:0] rid, input logic shr,
                          input bit typed, input moesi_pkg::rsp_type want);
      dir_row_type row;
      row.item = '{cmd, line, addr, rid, shr};
      row.typed = typed;
      row.want = want;
      dir_tab.push_back(row);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endtask

   // Offers one item from a falling edge and returns at the falling edge
   // after its transfer, with tvalid still high.
   task automatic offer_item(input coh_item_type it, input bit typed,
                             input moesi_pkg::rsp_type want);
      moesi_pkg::rsp_type pred;
      while ($urandom_range(99) < snd_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {3'b000, it.shr, it.rid, it.addr, it.line};
      req_tuser = it.cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pred = coherence_step(it);
      pending_rsp.push_back(typed ? want : pred);
      @(negedge clock);
   endtask

   task automatic pause_until_drained;
      req_tvalid = 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Most items run on sixteen lines spread over the index range, choosing
   // commands that move each line through complete coherence sequences.
   // The rest are unconstrained, reserved commands included.
   function automatic coh_item_type pick_item();
      coh_item_type it;
      int           r;
      it.addr = $urandom;
      it.rid = 4'($urandom_range(15));
      it.shr = 1'($urandom_range(1));
      r = $urandom_range(99);
      if ($urandom_range(99) < 75) begin
         it.line = 8'($urandom_range(15) * 17);
         case (line_shadow[it.line])
            moesi_pkg::ST_IM, moesi_pkg::ST_IS, moesi_pkg::ST_SM, moesi_pkg::ST_OM: begin
               if (r < 60) it.cmd = moesi_pkg::CMD_DATA;
               else if (r < 80) it.cmd = moesi_pkg::CMD_GETS;
               else if (r < 92) it.cmd = moesi_pkg::CMD_GETM;
               else if (r < 96) it.cmd = moesi_pkg::CMD_LOAD;
               else it.cmd = moesi_pkg::CMD_STORE;
            end
            default: begin
               if (r < 35) it.cmd = moesi_pkg::CMD_LOAD;
               else if (r < 60) it.cmd = moesi_pkg::CMD_STORE;
               else if (r < 78) it.cmd = moesi_pkg::CMD_GETS;
               else if (r < 95) it.cmd = moesi_pkg::CMD_GETM;
               else it.cmd = moesi_pkg::CMD_DATA;
            end
         endcase
      end else begin
         it.line = 8'($urandom_range(255));
         it.cmd = 3'($urandom_range(7));
      end
      return it;
   endfunction

   task automatic run_random(input int count);
      for (int n = 0; n < count; n++) offer_item(pick_item(), 1'b0, NO_FIXED);
   endtask

   // Result side: random stalls, or a counted hold-off when one is requested.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready = 1'b0;
            hold_left--;
         end else begin
            rsp_tready = ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      moesi_pkg::rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            $error("result transfer with no expected result: %0h", rsp_tdata);
            mismatches++;
         end else begin
            want = pending_rsp.pop_front();
            check_field("bus_request",    want.bus_request,    rsp_tdata[1:0]);
            check_field("data_on_bus",    want.data_on_bus,    rsp_tdata[2]);
            check_field("data_dest",      want.data_dest,      rsp_tdata[6:3]);
            check_field("out_addr",       want.out_addr,       rsp_tdata[38:7]);
            check_field("data_to_proc",   want.data_to_proc,   rsp_tdata[39]);
            check_field("assert_shared",  want.assert_shared,  rsp_tdata[40]);
            check_field("miss",           want.miss,           rsp_tdata[41]);
            check_field("silent_upgrade", want.silent_upgrade, rsp_tdata[42]);
            check_field("error_code",     want.error_code,     rsp_tdata[44:43]);
            check_field("new_state",      want.new_state,      rsp_tdata[48:45]);
            check_field("pad",            32'd0,               rsp_tdata[55:49]);
         end
      end
   end

   initial begin
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles = 0;
         else stall_cycles++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      mismatches = 0;
      hold_left = 0;
      snd_idle_pct = 28;
      rcv_idle_pct = 65;
      foreach (line_shadow[i]) line_shadow[i] = moesi_pkg::ST_I;

      // Line 0 walks through every stable and transient state except E.
      add_row(moesi_pkg::CMD_LOAD, 8'd0, 32'hFFFF_FFFF, 4'd0, 1'b0, 1'b1,
              fixed_rsp(moesi_pkg::BUS_GETS, 32'hFFFF_FFFF, 1'b1, moesi_pkg::ERR_NONE,
                        moesi_pkg::ST_IS));
      add_row(moesi_pkg::CMD_STORE, 8'd0, 32'h1234_5678, 4'd1, 1'b0, 1'b1,
              fixed_rsp(moesi_pkg::BUS_NONE, 32'd0, 1'b0, moesi_pkg::ERR_TRANSIENT,
                        moesi_pkg::ST_IS));
      add_row(moesi_pkg::CMD_DATA, 8'd0, 32'hFFFF_FFFF, 4'd2, 1'b1, 1'b0, NO_FIXED);
      add_row(moesi_pkg::CMD_DATA, 8'd0, 32'h0BAD_0BAD, 4'd3, 1'b0, 1'b1,
              fixed_rsp(moesi_pkg::BUS_NONE, 32'd0, 1'b0, moesi_pkg::ERR_UNEXPECTED,
                        moesi_pkg::ST_S));
      add_row(moesi_pkg::CMD_STORE, 8'd0, 32'hFFFF_FFFF, 4'd4, 1'b0, 1'b0, NO_FIXED);
      add_row(moesi_pkg::CMD_GETM, 8'd0, 32'hA5A5_A5A5, 4'd5, 1'b0, 1'b0, NO_FIXED);
      add_row(moesi_pkg::CMD_DATA, 8'd0, 32'hFFFF_FFFF, 4'd6, 1'b1, 1'b0, NO_FIXED);
      add_row(moesi_pkg::CMD_GETS, 8'd0, 32'hFFFF_FFFF, 4'd15, 1'b0, 1'b0, NO_FIXED);
      add_row(moesi_pkg::CMD_LOAD, 8'd0, 32'h5A5A_5A5A, 4'd7, 1'b1, 1'b0, NO_FIXED);
      add_row(moesi_pkg::CMD_STORE, 8'd0, 32'h8000_0000, 4'd8, 1'b0, 1'b0, NO_FIXED);
      add_row(moesi_pkg::CMD_GETS, 8'd0, 32'h7FFF_FFFF, 4'd9, 1'b1, 1'b0, NO_FIXED);
      add_row(moesi_pkg::CMD_DATA, 8'd0, 32'hFFFF_FFFF, 4'd10, 1'b0, 1'b0, NO_FIXED);
      add_row(moesi_pkg::CMD_GETS, 8'd0, 32'hFFFF_FFFF, 4'd11, 1'b0, 1'b0, NO_FIXED);
      add_row(moesi_pkg::CMD_STORE, 8'd0, 32'hFFFF_FFFF, 4'd12, 1'b0, 1'b0, NO_FIXED);
      add_row(moesi_pkg::CMD_GETM, 8'd0, 32'hFFFF_FFFF, 4'd15, 1'b0, 1'b0, NO_FIXED);
      add_row(moesi_pkg::CMD_DATA, 8'd0, 32'hC0DE_0001, 4'd13, 1'b1, 1'b0, NO_FIXED);
      add_row(moesi_pkg::CMD_GETM, 8'd0, 32'hFFFF_FFFF, 4'd14, 1'b1, 1'b0, NO_FIXED);
      // The far ends of the index range and the silent upgrade.
      add_row(moesi_pkg::CMD_STORE, 8'd255, 32'd0, 4'd0, 1'b0, 1'b1,
              fixed_rsp(moesi_pkg::BUS_GETM, 32'd0, 1'b1, moesi_pkg::ERR_NONE,
                        moesi_pkg::ST_IM));
      add_row(moesi_pkg::CMD_DATA, 8'd255, 32'd0, 4'd15, 1'b1, 1'b0, NO_FIXED);
      add_row(moesi_pkg::CMD_LOAD, 8'd128, 32'h8000_0001, 4'd0, 1'b0, 1'b1,
              fixed_rsp(moesi_pkg::BUS_GETS, 32'h8000_0001, 1'b1, moesi_pkg::ERR_NONE,
                        moesi_pkg::ST_IS));
      add_row(moesi_pkg::CMD_DATA, 8'd128, 32'h8000_0001, 4'd0, 1'b0, 1'b0, NO_FIXED);
      add_row(moesi_pkg::CMD_STORE, 8'd128, 32'h8000_0001, 4'd0, 1'b0, 1'b0, NO_FIXED);
      add_row(moesi_pkg::CMD_LOAD, 8'd1, 32'h0000_0040, 4'd0, 1'b0, 1'b1,
              fixed_rsp(moesi_pkg::BUS_GETS, 32'h0000_0040, 1'b1, moesi_pkg::ERR_NONE,
                        moesi_pkg::ST_IS));
      add_row(moesi_pkg::CMD_DATA, 8'd1, 32'h0000_0040, 4'd0, 1'b0, 1'b0, NO_FIXED);
      add_row(moesi_pkg::CMD_GETS, 8'd1, 32'h0000_0040, 4'd15, 1'b0, 1'b0, NO_FIXED);
      // Reserved command codes change nothing and report an unexpected message.
      add_row(CMD_RSVD_LO, 8'd1, 32'hFFFF_FFFF, 4'd15, 1'b1, 1'b1,
              fixed_rsp(moesi_pkg::BUS_NONE, 32'd0, 1'b0, moesi_pkg::ERR_UNEXPECTED,
                        moesi_pkg::ST_S));
      add_row(CMD_RSVD_HI, 8'd0, 32'hFFFF_FFFF, 4'd15, 1'b1, 1'b1,
              fixed_rsp(moesi_pkg::BUS_NONE, 32'd0, 1'b0, moesi_pkg::ERR_UNEXPECTED,
                        moesi_pkg::ST_I));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_tab[i]) offer_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
      run_random(PHASE_ITEMS);
      pause_until_drained();

      // The result side holds off while items keep coming, so the block
      // fills up and has to stall its input.
      snd_idle_pct = 65;
      rcv_idle_pct = 28;
      hold_left = 80;
      run_random(PHASE_ITEMS);
      pause_until_drained();

      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      hold_left = 60;
      run_random(PHASE_ITEMS + 1);
      pause_until_drained();
      repeat (8) @(posedge clock);

      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
